// ===== design/ptfsc_pkg.sv =====
`timescale 1ns / 1ps

package ptfsc_pkg;

  typedef enum logic [3:0] {
    OP_TICK       = 4'd0,
    OP_UP         = 4'd1,
    OP_DOWN       = 4'd2,
    OP_LEFT       = 4'd3,
    OP_RIGHT      = 4'd4,
    OP_STOP       = 4'd5,
    OP_TILT_ANGLE = 4'd6,
    OP_PAN_ANGLE  = 4'd7,
    OP_LOAD       = 4'd8,
    OP_FIRE       = 4'd9,
    OP_DIRECT     = 4'd10
  } op_t;

  localparam logic [1:0] CH_TILT = 2'd0;
  localparam logic [1:0] CH_PAN  = 2'd1;
  localparam logic [1:0] CH_FIRE = 2'd2;

  localparam logic [2:0] CFG_SPEED      = 3'd0;
  localparam logic [2:0] CFG_PAN_CENTER = 3'd1;
  localparam logic [2:0] CFG_GAIN       = 3'd2;
  localparam logic [2:0] CFG_TPD        = 3'd3;
  localparam logic [2:0] CFG_FIRE_TICKS = 3'd4;

  localparam logic [15:0] TILT_MAX  = 16'd4900;
  localparam logic [15:0] TILT_MIN  = 16'd2900;
  localparam logic [15:0] TILT_MID  = 16'd3900;
  localparam logic [15:0] FIRE_SHOT = 16'd5750;
  localparam logic [15:0] FIRE_REST = 16'd3000;
  localparam logic [15:0] PAN_SHIFT = 16'd96;

  localparam logic [3:0]  SPEED_RST      = 4'd2;
  localparam logic [15:0] PAN_CENTER_RST = 16'd4113;
  localparam logic [4:0]  GAIN_RST       = 5'd15;
  localparam logic [15:0] TPD_RST        = 16'd18000;
  localparam logic [23:0] FIRE_TICKS_RST = 24'd500000;

  localparam logic signed [15:0] TILT_ANGLE_LIM = 16'sd180;
  localparam logic signed [15:0] PAN_ANGLE_LIM  = 16'sd90;

  localparam logic [1:0] FACTOR_SLOW = 2'd1;
  localparam logic [1:0] FACTOR_FAST = 2'd3;

  typedef struct packed {
    logic load;
    logic update;
  } ptfsc_cmd_t;

endpackage

// ===== design/ptfsc_ctrl.sv =====
`timescale 1ns / 1ps

module ptfsc_ctrl import ptfsc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output ptfsc_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_UPDATE
  } state_t;

  state_t state;

  assign in_ready   = (state == S_IDLE);
  assign cmd.load   = in_valid && in_ready;
  assign cmd.update = (state == S_UPDATE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.load) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (cmd.update) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cmd.update) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/ptfsc_datapath.sv =====
`timescale 1ns / 1ps

module ptfsc_datapath import ptfsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ptfsc_cmd_t         cmd,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic [3:0]         opcode,
  input  logic               from_remote,
  input  logic signed [15:0] angle,
  input  logic [1:0]         channel,
  input  logic [15:0]        direct_value,
  output logic [15:0]        tilt_out,
  output logic [15:0]        pan_out,
  output logic [15:0]        fire_out,
  output logic               busy_res
);

  logic [3:0]  speed;
  logic [15:0] pan_center;
  logic [4:0]  gain;
  logic [15:0] tpd;
  logic [23:0] fire_ticks;

  logic [15:0] tilt_sp;
  logic [15:0] pan_sp;
  logic [15:0] fire_sp;
  logic [1:0]  up_factor;
  logic [1:0]  down_factor;
  logic [23:0] pan_timer;
  logic [23:0] fire_timer;

  logic [15:0] tilt_sp_next;
  logic [15:0] pan_sp_next;
  logic [15:0] fire_sp_next;
  logic [1:0]  up_factor_next;
  logic [1:0]  down_factor_next;
  logic [23:0] pan_timer_next;
  logic [23:0] fire_timer_next;

  op_t                op;
  logic               remote;
  logic [1:0]         chan;
  logic [15:0]        dval;
  logic [12:0]        step;
  logic signed [13:0] tilt_delta;
  logic               pan_pos;
  logic [23:0]        pan_ticks;

  op_t                op_in;
  logic [6:0]         step5;
  logic [1:0]         factor;
  logic [6:0]         gain_f;
  logic [13:0]        step_prod;
  logic [12:0]        step_sel;
  logic signed [8:0]  a_tilt;
  logic signed [13:0] a_ext;
  logic signed [13:0] tilt_delta_in;
  logic [6:0]         a_pan_mag;
  logic [22:0]        pan_prod;

  logic signed [17:0] tilt_ext;
  logic signed [17:0] step_ext;
  logic signed [17:0] delta_ext;
  logic signed [17:0] tilt_diff;
  logic signed [17:0] tilt_ang;
  logic [16:0]        tilt_sum;
  logic signed [17:0] pc_ext;
  logic signed [17:0] speed_ofs;
  logic signed [17:0] shift_ofs;
  logic signed [17:0] pan_plus;
  logic signed [17:0] pan_minus;
  logic signed [17:0] pan_plus96;
  logic signed [17:0] pan_minus96;
  logic signed [17:0] tilt_min_s;
  logic signed [17:0] tilt_max_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed      <= SPEED_RST;
      pan_center <= PAN_CENTER_RST;
      gain       <= GAIN_RST;
      tpd        <= TPD_RST;
      fire_ticks <= FIRE_TICKS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SPEED:      speed      <= cfg_data[3:0];
        CFG_PAN_CENTER: pan_center <= cfg_data[15:0];
        CFG_GAIN:       gain       <= cfg_data[4:0];
        CFG_TPD:        tpd        <= cfg_data[15:0];
        CFG_FIRE_TICKS: fire_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Step scaling and angle products are formed while the transaction is taken.
  always_comb begin
    op_in     = op_t'(opcode);
    step5     = 7'({speed, 2'b00}) + 7'(speed);
    factor    = (op_in == OP_DOWN) ? down_factor : up_factor;
    gain_f    = (factor == FACTOR_FAST) ? (7'(gain) + 7'({gain, 1'b0})) : 7'(gain);
    step_prod = 14'(step5) * 14'(gain_f);
    step_sel  = (from_remote && (op_in == OP_UP || op_in == OP_DOWN)) ?
                step_prod[12:0] : 13'(step5);

    if (angle > TILT_ANGLE_LIM) begin
      a_tilt = 9'sd180;
    end else if (angle < -TILT_ANGLE_LIM) begin
      a_tilt = -9'sd180;
    end else begin
      a_tilt = angle[8:0];
    end
    a_ext         = 14'(a_tilt);
    tilt_delta_in = (a_ext <<< 5) + a_ext;

    if (angle > PAN_ANGLE_LIM || angle < -PAN_ANGLE_LIM) begin
      a_pan_mag = 7'd90;
    end else if (angle > 16'sd0) begin
      a_pan_mag = angle[6:0];
    end else begin
      a_pan_mag = 7'(-angle);
    end
    pan_prod = 23'(a_pan_mag) * 23'(tpd);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op         <= op_in;
      remote     <= from_remote;
      chan       <= channel;
      dval       <= direct_value;
      step       <= step_sel;
      tilt_delta <= tilt_delta_in;
      pan_pos    <= (angle > 16'sd0);
      pan_ticks  <= 24'(pan_prod);
    end
  end

  always_comb begin
    tilt_ext    = {2'b00, tilt_sp};
    step_ext    = {5'b00000, step};
    delta_ext   = 18'(tilt_delta);
    tilt_diff   = tilt_ext - step_ext;
    tilt_ang    = tilt_ext - delta_ext;
    tilt_sum    = {1'b0, tilt_sp} + 17'(step);
    pc_ext      = {2'b00, pan_center};
    speed_ofs   = {9'd0, speed, 5'd0};
    shift_ofs   = {2'b00, PAN_SHIFT};
    pan_plus    = pc_ext + speed_ofs;
    pan_minus   = pc_ext - speed_ofs;
    pan_plus96  = pc_ext + shift_ofs;
    pan_minus96 = pc_ext - shift_ofs;
    tilt_min_s  = {2'b00, TILT_MIN};
    tilt_max_s  = {2'b00, TILT_MAX};

    tilt_sp_next     = tilt_sp;
    pan_sp_next      = pan_sp;
    fire_sp_next     = fire_sp;
    up_factor_next   = up_factor;
    down_factor_next = down_factor;
    pan_timer_next   = pan_timer;
    fire_timer_next  = fire_timer;

    case (op)
      OP_TICK: begin
        if (pan_timer != 24'd0) begin
          pan_timer_next = pan_timer - 24'd1;
          if (pan_timer == 24'd1) begin
            pan_sp_next = pan_center;
          end
        end
        if (fire_timer != 24'd0) begin
          fire_timer_next = fire_timer - 24'd1;
          if (fire_timer == 24'd1) begin
            fire_sp_next = FIRE_REST;
          end
        end
      end
      OP_UP: begin
        if (tilt_sp > TILT_MIN) begin
          if (remote) begin
            up_factor_next   = FACTOR_SLOW;
            down_factor_next = FACTOR_FAST;
          end
          tilt_sp_next = (tilt_diff < tilt_min_s) ? TILT_MIN : tilt_diff[15:0];
        end
      end
      OP_DOWN: begin
        if (tilt_sp < TILT_MAX) begin
          if (remote) begin
            up_factor_next   = FACTOR_FAST;
            down_factor_next = FACTOR_SLOW;
          end
          tilt_sp_next = (tilt_sum > 17'(TILT_MAX)) ? TILT_MAX : tilt_sum[15:0];
        end
      end
      OP_LEFT: begin
        pan_sp_next    = pan_plus[16] ? 16'hFFFF : pan_plus[15:0];
        pan_timer_next = 24'd0;
      end
      OP_RIGHT: begin
        pan_sp_next    = pan_minus[17] ? 16'd0 : pan_minus[15:0];
        pan_timer_next = 24'd0;
      end
      OP_STOP: begin
        pan_sp_next    = pan_center;
        pan_timer_next = 24'd0;
      end
      OP_TILT_ANGLE: begin
        if (tilt_ang < tilt_min_s) begin
          tilt_sp_next = TILT_MIN;
        end else if (tilt_ang > tilt_max_s) begin
          tilt_sp_next = TILT_MAX;
        end else begin
          tilt_sp_next = tilt_ang[15:0];
        end
      end
      OP_PAN_ANGLE: begin
        pan_timer_next = pan_ticks;
        if (pan_ticks == 24'd0) begin
          pan_sp_next = pan_center;
        end else if (pan_pos) begin
          pan_sp_next = pan_minus96[17] ? 16'd0 : pan_minus96[15:0];
        end else begin
          pan_sp_next = pan_plus96[16] ? 16'hFFFF : pan_plus96[15:0];
        end
      end
      OP_LOAD: begin
        fire_sp_next    = FIRE_REST;
        fire_timer_next = 24'd0;
      end
      OP_FIRE: begin
        fire_timer_next = fire_ticks;
        fire_sp_next    = (fire_ticks == 24'd0) ? FIRE_REST : FIRE_SHOT;
      end
      OP_DIRECT: begin
        case (chan)
          CH_TILT: begin
            tilt_sp_next = dval;
          end
          CH_PAN: begin
            pan_sp_next    = dval;
            pan_timer_next = 24'd0;
          end
          CH_FIRE: begin
            fire_sp_next    = dval;
            fire_timer_next = 24'd0;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_sp     <= TILT_MID;
      pan_sp      <= PAN_CENTER_RST;
      fire_sp     <= FIRE_REST;
      up_factor   <= FACTOR_SLOW;
      down_factor <= FACTOR_SLOW;
      pan_timer   <= 24'd0;
      fire_timer  <= 24'd0;
    end else if (cmd.update) begin
      tilt_sp     <= tilt_sp_next;
      pan_sp      <= pan_sp_next;
      fire_sp     <= fire_sp_next;
      up_factor   <= up_factor_next;
      down_factor <= down_factor_next;
      pan_timer   <= pan_timer_next;
      fire_timer  <= fire_timer_next;
    end
  end

  // The setpoints only change when a new result is loaded, so they serve as the output register.
  assign tilt_out = tilt_sp;
  assign pan_out  = pan_sp;
  assign fire_out = fire_sp;
  assign busy_res = (pan_timer != 24'd0) || (fire_timer != 24'd0);

endmodule

// ===== design/pan_tilt_fire_servo_commander_unit.sv =====
// A result becomes valid once the controller's update state has written the setpoints;
// a new transaction is accepted only after the last one finishes in the two-state controller
// (capture and multiply, then setpoint update); a stalled output holds the update.
// Reset: synchronous, active high; restores register defaults, setpoints and timers at once.
`timescale 1ns / 1ps

module pan_tilt_fire_servo_commander_unit import ptfsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         opcode,
  input  logic               from_remote,
  input  logic signed [15:0] angle,
  input  logic [1:0]         channel,
  input  logic [15:0]        direct_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        tilt_out,
  output logic [15:0]        pan_out,
  output logic [15:0]        fire_out,
  output logic               busy_res,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  ptfsc_cmd_t cmd;

  ptfsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ptfsc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .opcode       (opcode),
    .from_remote  (from_remote),
    .angle        (angle),
    .channel      (channel),
    .direct_value (direct_value),
    .tilt_out     (tilt_out),
    .pan_out      (pan_out),
    .fire_out     (fire_out),
    .busy_res     (busy_res)
  );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ptfsc_pkg::*;

  localparam logic [1:0] CH_NONE = 2'd3;
  localparam int TILT_STEP_PER_SPEED = 5;
  localparam int PAN_STEP_PER_SPEED = 32;
  localparam int TILT_PER_DEGREE = 33;
  localparam int RANDOM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 90;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    op_t                opcode;
    logic               from_remote;
    logic signed [15:0] angle;
    logic [1:0]         channel;
    logic [15:0]        direct_value;
  } turret_cmd_t;

  typedef struct {
    logic [15:0] tilt;
    logic [15:0] pan;
    logic [15:0] fire;
    logic        busy;
  } servo_state_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [3:0]         opcode = 4'd0;
  logic               from_remote = 1'b0;
  logic signed [15:0] angle = 16'sd0;
  logic [1:0]         channel = 2'd0;
  logic [15:0]        direct_value = 16'd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [15:0]        tilt_out;
  logic [15:0]        pan_out;
  logic [15:0]        fire_out;
  logic               busy_res;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = 3'd0;
  logic [23:0]        cfg_data = 24'd0;

  pan_tilt_fire_servo_commander_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .from_remote(from_remote),
    .angle(angle),
    .channel(channel),
    .direct_value(direct_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .tilt_out(tilt_out),
    .pan_out(pan_out),
    .fire_out(fire_out),
    .busy_res(busy_res),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Register copies and turret state kept by the predictor.
  logic [3:0]  cfg_speed;
  logic [15:0] cfg_pan_center;
  logic [4:0]  cfg_gain;
  logic [15:0] cfg_ticks_per_deg;
  logic [23:0] cfg_fire_ticks;
  logic [15:0] tilt_sp, pan_sp, fire_sp;
  logic [1:0]  up_factor, down_factor;
  logic [23:0] pan_timer, fire_timer;

  turret_cmd_t  pending_cmds[$];
  servo_state_t expected_setpoints[$];
  turret_cmd_t  cur_cmd;

  int failures = 0;
  int cmds_sent = 0;
  int results_checked = 0;
  int timer_expiries = 0;
  int settings_used = 1;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_request = 1'b0;
  int rx_cycle = 0;
  int rx_style = 0;

  function automatic logic [15:0] sat16(input int v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return 16'(v);
  endfunction

  function automatic int clamp_int(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic reset_turret_model();
    cfg_speed = SPEED_RST;
    cfg_pan_center = PAN_CENTER_RST;
    cfg_gain = GAIN_RST;
    cfg_ticks_per_deg = TPD_RST;
    cfg_fire_ticks = FIRE_TICKS_RST;
    tilt_sp = TILT_MID;
    pan_sp = PAN_CENTER_RST;
    fire_sp = FIRE_REST;
    up_factor = FACTOR_SLOW;
    down_factor = FACTOR_SLOW;
    pan_timer = 24'd0;
    fire_timer = 24'd0;
  endtask

  task automatic advance_turret(input turret_cmd_t c);
    int step, pc, a, t;
    servo_state_t r;
    step = TILT_STEP_PER_SPEED * int'(cfg_speed);
    pc = int'(cfg_pan_center);
    case (c.opcode)
      OP_TICK: begin
        if (pan_timer != 0) begin
          pan_timer--;
          if (pan_timer == 0) begin
            pan_sp = cfg_pan_center;
            timer_expiries++;
          end
        end
        if (fire_timer != 0) begin
          fire_timer--;
          if (fire_timer == 0) begin
            fire_sp = FIRE_REST;
            timer_expiries++;
          end
        end
      end
      OP_UP: begin
        if (tilt_sp > TILT_MIN) begin
          if (c.from_remote) begin
            step = step * int'(cfg_gain) * int'(up_factor);
            up_factor = FACTOR_SLOW;
            down_factor = FACTOR_FAST;
          end
          t = int'(tilt_sp) - step;
          tilt_sp = (t < int'(TILT_MIN)) ? TILT_MIN : 16'(t);
        end
      end
      OP_DOWN: begin
        if (tilt_sp < TILT_MAX) begin
          if (c.from_remote) begin
            step = step * int'(cfg_gain) * int'(down_factor);
            up_factor = FACTOR_FAST;
            down_factor = FACTOR_SLOW;
          end
          t = int'(tilt_sp) + step;
          tilt_sp = (t > int'(TILT_MAX)) ? TILT_MAX : 16'(t);
        end
      end
      OP_LEFT: begin
        pan_sp = sat16(pc + PAN_STEP_PER_SPEED * int'(cfg_speed));
        pan_timer = 24'd0;
      end
      OP_RIGHT: begin
        pan_sp = sat16(pc - PAN_STEP_PER_SPEED * int'(cfg_speed));
        pan_timer = 24'd0;
      end
      OP_STOP: begin
        pan_sp = cfg_pan_center;
        pan_timer = 24'd0;
      end
      OP_TILT_ANGLE: begin
        a = clamp_int(int'(c.angle), -int'(TILT_ANGLE_LIM), int'(TILT_ANGLE_LIM));
        tilt_sp = 16'(clamp_int(int'(tilt_sp) - a * TILT_PER_DEGREE,
                                int'(TILT_MIN), int'(TILT_MAX)));
      end
      OP_PAN_ANGLE: begin
        a = clamp_int(int'(c.angle), -int'(PAN_ANGLE_LIM), int'(PAN_ANGLE_LIM));
        if (a > 0) begin
          pan_sp = sat16(pc - int'(PAN_SHIFT));
        end else begin
          pan_sp = sat16(pc + int'(PAN_SHIFT));
          a = -a;
        end
        pan_timer = 24'(a * int'(cfg_ticks_per_deg));
        if (pan_timer == 0) pan_sp = cfg_pan_center;
      end
      OP_LOAD: begin
        fire_sp = FIRE_REST;
        fire_timer = 24'd0;
      end
      OP_FIRE: begin
        fire_sp = FIRE_SHOT;
        fire_timer = cfg_fire_ticks;
        if (fire_timer == 0) fire_sp = FIRE_REST;
      end
      OP_DIRECT: begin
        case (c.channel)
          CH_TILT: tilt_sp = c.direct_value;
          CH_PAN: begin
            pan_sp = c.direct_value;
            pan_timer = 24'd0;
          end
          CH_FIRE: begin
            fire_sp = c.direct_value;
            fire_timer = 24'd0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.tilt = tilt_sp;
    r.pan = pan_sp;
    r.fire = fire_sp;
    r.busy = (pan_timer != 0) || (fire_timer != 0);
    expected_setpoints.push_back(r);
  endtask

  function automatic turret_cmd_t make_cmd(input op_t op, input logic remote,
                                           input logic signed [15:0] ang,
                                           input logic [1:0] ch, input logic [15:0] val);
    turret_cmd_t c;
    c.opcode = op;
    c.from_remote = remote;
    c.angle = ang;
    c.channel = ch;
    c.direct_value = val;
    return c;
  endfunction

  function automatic turret_cmd_t random_cmd();
    turret_cmd_t c;
    c.opcode = ($urandom_range(0, 99) < 35) ? OP_TICK : op_t'($urandom_range(1, 10));
    c.from_remote = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: c.angle = 16'($urandom);
      1: c.angle = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      2: c.angle = 16'(int'($urandom_range(0, 400)) - 200);
      default: c.angle = 16'(int'($urandom_range(0, 12)) - 6);
    endcase
    c.channel = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0: c.direct_value = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
      1: c.direct_value = 16'($urandom_range(2800, 5000));
      default: c.direct_value = 16'($urandom);
    endcase
    return c;
  endfunction

  task automatic set_reg(input logic [2:0] idx, input logic [23:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_SPEED:      cfg_speed = data[3:0];
      CFG_PAN_CENTER: cfg_pan_center = data[15:0];
      CFG_GAIN:       cfg_gain = data[4:0];
      CFG_TPD:        cfg_ticks_per_deg = data[15:0];
      CFG_FIRE_TICKS: cfg_fire_ticks = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || in_valid || expected_setpoints.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        advance_turret(cur_cmd);
        cmds_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          opcode <= cur_cmd.opcode;
          from_remote <= cur_cmd.from_remote;
          angle <= cur_cmd.angle;
          channel <= cur_cmd.channel;
          direct_value <= cur_cmd.direct_value;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transaction and stalls on its own pattern.
  always @(posedge clk) begin : rx_side
    servo_state_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_setpoints.size() == 0) begin
          $error("result transaction with no expectation pending");
          failures++;
        end else begin
          want = expected_setpoints.pop_front();
          results_checked++;
          if (tilt_out !== want.tilt) begin
            $error("tilt_out: expected %0d, actual %0d", want.tilt, tilt_out);
            failures++;
          end
          if (pan_out !== want.pan) begin
            $error("pan_out: expected %0d, actual %0d", want.pan, pan_out);
            failures++;
          end
          if (fire_out !== want.fire) begin
            $error("fire_out: expected %0d, actual %0d", want.fire, fire_out);
            failures++;
          end
          if (busy_res !== want.busy) begin
            $error("busy_res: expected %0d, actual %0d", want.busy, busy_res);
            failures++;
          end
        end
      end
      rx_cycle++;
      if (rx_cycle % 128 == 0) rx_style = $urandom_range(0, 2);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_style)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 2) != 0);
          default: out_ready <= ((rx_cycle % 7) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int phase, n, run;
    logic [3:0]  spd;
    logic [15:0] pcen;
    logic [4:0]  gn;
    logic [15:0] tpd;
    logic [23:0] fpt;

    reset_turret_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed commands at the reset register values.
    pending_cmds.push_back(make_cmd(OP_TICK, 1'b0, 16'sd0, CH_TILT, 16'd0));
    pending_cmds.push_back(make_cmd(OP_UP, 1'b0, 16'sd0, CH_TILT, 16'd0));
    pending_cmds.push_back(make_cmd(OP_UP, 1'b1, 16'sd0, CH_TILT, 16'd0));
    pending_cmds.push_back(make_cmd(OP_DOWN, 1'b1, 16'sd0, CH_TILT, 16'd0));
    pending_cmds.push_back(make_cmd(OP_UP, 1'b1, 16'sd0, CH_TILT, 16'd0));
    pending_cmds.push_back(make_cmd(OP_TILT_ANGLE, 1'b0, 16'sh7FFF, CH_TILT, 16'd0));
    pending_cmds.push_back(make_cmd(OP_UP, 1'b1, 16'sd0, CH_TILT, 16'd0));
    pending_cmds.push_back(make_cmd(OP_TILT_ANGLE, 1'b0, 16'sh8000, CH_TILT, 16'd0));
    pending_cmds.push_back(make_cmd(OP_DOWN, 1'b0, 16'sd0, CH_TILT, 16'd0));
    pending_cmds.push_back(make_cmd(OP_LEFT, 1'b1, 16'sd0, CH_TILT, 16'd0));
    pending_cmds.push_back(make_cmd(OP_RIGHT, 1'b0, 16'sd0, CH_TILT, 16'd0));
    pending_cmds.push_back(make_cmd(OP_STOP, 1'b0, 16'sd0, CH_TILT, 16'd0));
    pending_cmds.push_back(make_cmd(OP_PAN_ANGLE, 1'b0, 16'sh7FFF, CH_TILT, 16'd0));
    pending_cmds.push_back(make_cmd(OP_PAN_ANGLE, 1'b0, 16'sd0, CH_TILT, 16'd0));
    pending_cmds.push_back(make_cmd(OP_PAN_ANGLE, 1'b0, -16'sd5, CH_TILT, 16'd0));
    pending_cmds.push_back(make_cmd(OP_FIRE, 1'b0, 16'sd0, CH_TILT, 16'd0));
    pending_cmds.push_back(make_cmd(OP_TICK, 1'b0, 16'sd0, CH_TILT, 16'd0));
    pending_cmds.push_back(make_cmd(OP_LOAD, 1'b0, 16'sd0, CH_TILT, 16'd0));
    pending_cmds.push_back(make_cmd(OP_DIRECT, 1'b0, 16'sd0, CH_TILT, 16'hFFFF));
    pending_cmds.push_back(make_cmd(OP_TILT_ANGLE, 1'b1, 16'sd1, CH_TILT, 16'd0));
    pending_cmds.push_back(make_cmd(OP_DIRECT, 1'b0, 16'sd0, CH_PAN, 16'd0));
    pending_cmds.push_back(make_cmd(OP_DIRECT, 1'b0, 16'sd0, CH_FIRE, 16'hFFFF));
    pending_cmds.push_back(make_cmd(OP_DIRECT, 1'b1, -16'sd1, CH_NONE, 16'h5A5A));
    pending_cmds.push_back(make_cmd(OP_DIRECT, 1'b0, 16'sd0, CH_TILT, 16'd0));
    pending_cmds.push_back(make_cmd(OP_DOWN, 1'b0, 16'sd0, CH_TILT, 16'd0));
    wait_idle();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          spd = 4'd15; pcen = 16'hFFFF; gn = 5'd31; tpd = 16'hFFFF; fpt = 24'hFFFFFF;
        end
        1: begin
          spd = 4'd0; pcen = 16'd0; gn = 5'd0; tpd = 16'd0; fpt = 24'd0;
        end
        2: begin
          spd = 4'd15; pcen = 16'd0; gn = 5'd31; tpd = 16'd1; fpt = 24'd1;
        end
        3: begin
          spd = 4'd1; pcen = 16'd65500; gn = 5'd1; tpd = 16'd2; fpt = 24'd5;
        end
        default: begin
          spd = 4'($urandom_range(0, 15));
          case ($urandom_range(0, 2))
            0: pcen = 16'($urandom_range(0, 600));
            1: pcen = 16'($urandom_range(64900, 65535));
            default: pcen = 16'($urandom);
          endcase
          gn = 5'($urandom_range(0, 31));
          tpd = 16'($urandom_range(0, 3));
          fpt = 24'($urandom_range(0, 20));
        end
      endcase
      set_reg(CFG_SPEED, {20'd0, spd});
      set_reg(CFG_PAN_CENTER, {8'd0, pcen});
      set_reg(CFG_GAIN, {19'd0, gn});
      set_reg(CFG_TPD, {8'd0, tpd});
      set_reg(CFG_FIRE_TICKS, fpt);
      settings_used++;
      @(negedge clk);

      // The receiver blocks for a long stretch while the sender keeps offering.
      if (phase == 3) hold_request = 1'b1;

      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) == 0) begin
          // A timed pan or fire pulse followed by a random run of ticks.
          pending_cmds.push_back(make_cmd($urandom_range(0, 1) ? OP_FIRE : OP_PAN_ANGLE,
                                          1'b0, 16'(int'($urandom_range(0, 8)) - 4),
                                          CH_TILT, 16'd0));
          run = $urandom_range(1, 30);
          repeat (run) pending_cmds.push_back(make_cmd(OP_TICK, 1'b0, 16'sd0, CH_TILT, 16'd0));
          n += run + 1;
        end else begin
          pending_cmds.push_back(random_cmd());
          n++;
        end
        // The sender pauses until every outstanding result has come back.
        if (phase == 5 && n == ITEMS_PER_PHASE / 2) wait_idle();
      end
      wait_idle();
    end

    if (expected_setpoints.size() != 0) begin
      $error("%0d expected results never arrived", expected_setpoints.size());
      failures++;
    end
    $display("Sent %0d commands under %0d register settings and checked %0d results.",
             cmds_sent, settings_used, results_checked);
    $display("The predictor saw %0d pan or fire timers run out.", timer_expiries);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== pan_tilt_fire_servo_commander_unit.f =====
design/ptfsc_pkg.sv
design/ptfsc_ctrl.sv
design/ptfsc_datapath.sv
design/pan_tilt_fire_servo_commander_unit.sv
bench/testbench.sv
